@@ hw/rtl/bir_pkg.sv @@
// Shared types and constants for the bilinear image resampler.
// Holds field widths, stream packing offsets, register indexes and reset values.
// No dependencies.
`default_nettype none

package bir_pkg;

    // Parameter defaults handed to the top level.
    localparam int MAX_WIDTH_DEF     = 256;
    localparam int MAX_HEIGHT_DEF    = 256;
    localparam int FRACTION_BITS_DEF = 12;

    // Fixed field widths.
    localparam int COORD_W    = 11;
    localparam int CHAN_W     = 8;
    localparam int NUM_CHAN   = 3;
    localparam int PIX_W      = NUM_CHAN * CHAN_W;
    localparam int SIZE_REG_W = 9;
    localparam int SCALE_W    = 16;
    // Wide enough for any image size up to 2048 plus one.
    localparam int SIZE_W     = 12;
    localparam int PROD_W     = COORD_W + SCALE_W;

    // Stream packing, lowest bit first.
    localparam int COL_LSB     = 0;
    localparam int ROW_LSB     = COL_LSB + COORD_W;
    localparam int PIX_LSB     = ROW_LSB + COORD_W;
    localparam int S_TDATA_W   = 48;
    localparam int S_TUSER_W   = 1;
    localparam int M_TDATA_W   = PIX_W;

    // Configuration port.
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = SCALE_W;

    localparam logic [SIZE_REG_W-1:0] SOURCE_WIDTH_RST  = 9'd256;
    localparam logic [SIZE_REG_W-1:0] SOURCE_HEIGHT_RST = 9'd256;
    localparam logic [SCALE_W-1:0]    INVERSE_SCALE_RST = 16'd8192;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_SOURCE_WIDTH  = 2'd0,
        CFG_SOURCE_HEIGHT = 2'd1,
        CFG_INVERSE_SCALE = 2'd2
    } cfg_index_t;

    typedef enum logic {
        OP_WRITE   = 1'b0,
        OP_REQUEST = 1'b1
    } op_t;

    // Channel 0 is blue, 1 green, 2 red.
    typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] pixel_t;

endpackage

`default_nettype wire

@@ hw/rtl/bilinear_image_resampler.sv @@
// Bilinear image resampler: frame store in four parity banks plus blend pipeline.
// Depends on bir_pkg for widths, packing offsets, register indexes and types.
`default_nettype none

// Usage
// The slave stream carries one transaction per item. s_tuser[0] is the operation:
// a write stores the pixel in s_tdata at its column and row and gives no result;
// a request names a destination column and row and gives exactly one result
// transaction on the master stream with the interpolated blue, green and red.
// The frame store is split into four banks by row and column parity, so the
// four neighbours of any source position are read from the four banks
// together. The block therefore takes one transaction per cycle while
// s_tready is high, writes and requests mixed freely, and each result is
// registered at the output. Writes and reads reach the banks in arrival order
// at the same pipeline stage, so a request always sees every earlier write.
// Reset clears the pipeline and loads the size and scale registers with their
// defaults; the frame store is not cleared and must be written before it is
// read. When the receiver stalls, results collect in the pipeline stages and
// s_tready only drops once every stage holds an item. Configuration registers
// are written by the user through cfg_wr_en while the block is idle (not enforced).

module bilinear_image_resampler #(
    parameter int MAX_WIDTH     = bir_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT    = bir_pkg::MAX_HEIGHT_DEF,
    parameter int FRACTION_BITS = bir_pkg::FRACTION_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Slave stream.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata: column[10:0], row[21:11], in_blue[29:22], in_green[37:30],
    // in_red[45:38], zero padding[47:46].
    input  logic [bir_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tuser: op[0].
    input  logic [bir_pkg::S_TUSER_W-1:0]    s_tuser,
    // Master stream.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata: out_blue[7:0], out_green[15:8], out_red[23:16].
    output logic [bir_pkg::M_TDATA_W-1:0]    m_tdata,
    // Configuration write port.
    input  logic                             cfg_wr_en,
    input  logic [bir_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [bir_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);
    import bir_pkg::*;

    localparam int FB         = FRACTION_BITS;
    localparam int CW         = $clog2(MAX_WIDTH);
    localparam int RH         = $clog2(MAX_HEIGHT);
    localparam int XHW        = (CW > 1) ? CW - 1 : 1;
    localparam int YHW        = (RH > 1) ? RH - 1 : 1;
    localparam int AW         = XHW + YHW;
    localparam int BANK_DEPTH = 1 << AW;
    localparam int IXW        = PROD_W - FB;
    localparam int HW         = FB + CHAN_W;
    localparam int VW         = 2 * FB + CHAN_W;
    localparam int RW         = VW + 1 - 2 * FB;

    localparam logic [FB:0] ONE_Q   = {1'b1, {FB{1'b0}}};
    localparam logic [VW:0] ROUND_C = (VW + 1)'(1) << (2 * FB - 1);

    // ---------------- configuration registers ----------------
    logic [SIZE_REG_W-1:0] source_width_reg;
    logic [SIZE_REG_W-1:0] source_height_reg;
    logic [SCALE_W-1:0]    inverse_scale_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_width_reg  <= SOURCE_WIDTH_RST;
            source_height_reg <= SOURCE_HEIGHT_RST;
            inverse_scale_reg <= INVERSE_SCALE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_addr))
                CFG_SOURCE_WIDTH:  source_width_reg  <= cfg_wr_data[SIZE_REG_W-1:0];
                CFG_SOURCE_HEIGHT: source_height_reg <= cfg_wr_data[SIZE_REG_W-1:0];
                CFG_INVERSE_SCALE: inverse_scale_reg <= cfg_wr_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- stage handshake chain ----------------
    logic b_valid_reg, c_valid_reg, d_valid_reg, e_valid_reg, m_valid_reg;
    logic b_go, c_go, d_go, e_go, m_go;

    assign m_go     = !m_valid_reg || m_tready;
    assign e_go     = !e_valid_reg || m_go;
    assign d_go     = !d_valid_reg || e_go;
    assign c_go     = !c_valid_reg || d_go;
    assign b_go     = !b_valid_reg || c_go;
    assign s_tready = b_go;

    // ---------------- stage B: source position ----------------
    logic [COORD_W-1:0] s_col, s_row;
    pixel_t             s_pix;
    logic [PROD_W-1:0]  mul_x, mul_y;

    assign s_col = s_tdata[COL_LSB +: COORD_W];
    assign s_row = s_tdata[ROW_LSB +: COORD_W];
    assign s_pix = pixel_t'(s_tdata[PIX_LSB +: PIX_W]);
    assign mul_x = PROD_W'(s_col) * PROD_W'(inverse_scale_reg);
    assign mul_y = PROD_W'(s_row) * PROD_W'(inverse_scale_reg);

    op_t                b_op_reg;
    logic [COORD_W-1:0] b_col_reg, b_row_reg;
    pixel_t             b_pix_reg;
    logic [PROD_W-1:0]  b_px_reg, b_py_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_go) begin
            b_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_go && s_tvalid) begin
            b_op_reg  <= op_t'(s_tuser[0]);
            b_col_reg <= s_col;
            b_row_reg <= s_row;
            b_pix_reg <= s_pix;
            b_px_reg  <= mul_x;
            b_py_reg  <= mul_y;
        end
    end

    // Edge clamping of the neighbour coordinates. A size register of zero acts
    // as one and a size above the store acts as the store size.
    logic [SIZE_W-1:0] w_raw, h_raw, w_eff, h_eff, wm1, hm1;
    logic [IXW:0]      ix_e, iy_e, ix_inc, iy_inc, wm1_e, hm1_e;
    logic              x_same, y_same;
    logic [CW-1:0]     x0, x1;
    logic [RH-1:0]     y0, y1;
    logic [FB-1:0]     fx, fy;

    always_comb begin
        w_raw = SIZE_W'(source_width_reg);
        h_raw = SIZE_W'(source_height_reg);
        if (w_raw == '0) begin
            w_eff = SIZE_W'(1);
        end else if (w_raw > SIZE_W'(MAX_WIDTH)) begin
            w_eff = SIZE_W'(MAX_WIDTH);
        end else begin
            w_eff = w_raw;
        end
        if (h_raw == '0) begin
            h_eff = SIZE_W'(1);
        end else if (h_raw > SIZE_W'(MAX_HEIGHT)) begin
            h_eff = SIZE_W'(MAX_HEIGHT);
        end else begin
            h_eff = h_raw;
        end
        wm1   = w_eff - SIZE_W'(1);
        hm1   = h_eff - SIZE_W'(1);
        wm1_e = (IXW + 1)'(wm1);
        hm1_e = (IXW + 1)'(hm1);

        ix_e   = (IXW + 1)'(b_px_reg[PROD_W-1:FB]);
        iy_e   = (IXW + 1)'(b_py_reg[PROD_W-1:FB]);
        ix_inc = ix_e + (IXW + 1)'(1);
        iy_inc = iy_e + (IXW + 1)'(1);
        fx     = b_px_reg[FB-1:0];
        fy     = b_py_reg[FB-1:0];

        // At or past the last valid column or row both neighbours collapse onto it.
        x_same = (ix_e >= wm1_e);
        y_same = (iy_e >= hm1_e);
        x0 = x_same ? CW'(wm1) : CW'(ix_e);
        y0 = y_same ? RH'(hm1) : RH'(iy_e);
        x1 = (ix_inc >= wm1_e) ? CW'(wm1) : CW'(ix_inc);
        y1 = (iy_inc >= hm1_e) ? RH'(hm1) : RH'(iy_inc);
    end

    // Each parity bank reads whichever neighbour has its parity. Bank index
    // is {row parity, column parity}.
    logic [1:0][XHW-1:0] col_half;
    logic [1:0][YHW-1:0] row_half;
    logic [3:0][AW-1:0]  rd_addr;

    always_comb begin
        for (int p = 0; p < 2; p++) begin
            col_half[p] = (x0[0] == 1'(p)) ? XHW'(x0 >> 1) : XHW'(x1 >> 1);
            row_half[p] = (y0[0] == 1'(p)) ? YHW'(y0 >> 1) : YHW'(y1 >> 1);
        end
        for (int k = 0; k < 4; k++) begin
            rd_addr[k] = {row_half[k / 2], col_half[k % 2]};
        end
    end

    // Pixel writes go to the bank of their own parity.
    logic          wr_en;
    logic [1:0]    wr_bank;
    logic [AW-1:0] wr_addr;
    logic          wr_in_store;

    assign wr_in_store = ({1'b0, b_col_reg} < (COORD_W + 1)'(MAX_WIDTH))
                      && ({1'b0, b_row_reg} < (COORD_W + 1)'(MAX_HEIGHT));
    assign wr_en   = b_valid_reg && (b_op_reg == OP_WRITE) && c_go && wr_in_store;
    assign wr_bank = {b_row_reg[0], b_col_reg[0]};
    assign wr_addr = {YHW'(RH'(b_row_reg) >> 1), XHW'(CW'(b_col_reg) >> 1)};

    // ---------------- frame store banks ----------------
    pixel_t bank_q_reg [4];

    for (genvar k = 0; k < 4; k++) begin : g_bank
        pixel_t frame_mem [BANK_DEPTH];

        always_ff @(posedge aclk) begin
            if (wr_en && (wr_bank == 2'(k))) begin
                frame_mem[wr_addr] <= b_pix_reg;
            end
            if (c_go) begin
                bank_q_reg[k] <= frame_mem[rd_addr[k]];
            end
        end
    end

    // ---------------- stage C: neighbours arrive ----------------
    logic          c_xpar_reg, c_ypar_reg, c_xsame_reg, c_ysame_reg;
    logic [FB-1:0] c_fx_reg, c_fy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (c_go) begin
            c_valid_reg <= b_valid_reg && (b_op_reg == OP_REQUEST);
        end
    end

    always_ff @(posedge aclk) begin
        if (c_go) begin
            c_xpar_reg  <= x0[0];
            c_ypar_reg  <= y0[0];
            c_xsame_reg <= x_same;
            c_ysame_reg <= y_same;
            c_fx_reg    <= fx;
            c_fy_reg    <= fy;
        end
    end

    pixel_t p00, p10, p01, p11;

    always_comb begin
        p00 = bank_q_reg[{c_ypar_reg, c_xpar_reg}];
        p10 = c_xsame_reg ? p00 : bank_q_reg[{c_ypar_reg, ~c_xpar_reg}];
        p01 = c_ysame_reg ? p00 : bank_q_reg[{~c_ypar_reg, c_xpar_reg}];
        if (c_xsame_reg) begin
            p11 = p01;
        end else if (c_ysame_reg) begin
            p11 = p10;
        end else begin
            p11 = bank_q_reg[{~c_ypar_reg, ~c_xpar_reg}];
        end
    end

    // Horizontal blend of each row pair; the vertical blend of these partial
    // sums equals the four-weight sum exactly.
    logic [FB:0]                   wl_x;
    logic [NUM_CHAN-1:0][HW-1:0]   h_top, h_bot;

    always_comb begin
        wl_x = ONE_Q - {1'b0, c_fx_reg};
        for (int ch = 0; ch < NUM_CHAN; ch++) begin
            h_top[ch] = HW'(wl_x) * HW'(p00[ch]) + HW'(c_fx_reg) * HW'(p10[ch]);
            h_bot[ch] = HW'(wl_x) * HW'(p01[ch]) + HW'(c_fx_reg) * HW'(p11[ch]);
        end
    end

    // ---------------- stage D: horizontal sums ----------------
    logic [NUM_CHAN-1:0][HW-1:0] d_top_reg, d_bot_reg;
    logic [FB-1:0]               d_fy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (d_go) begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (d_go) begin
            d_top_reg <= h_top;
            d_bot_reg <= h_bot;
            d_fy_reg  <= c_fy_reg;
        end
    end

    logic [FB:0]                 wl_y;
    logic [NUM_CHAN-1:0][VW-1:0] v_sum;

    always_comb begin
        wl_y = ONE_Q - {1'b0, d_fy_reg};
        for (int ch = 0; ch < NUM_CHAN; ch++) begin
            v_sum[ch] = VW'(wl_y) * VW'(d_top_reg[ch]) + VW'(d_fy_reg) * VW'(d_bot_reg[ch]);
        end
    end

    // ---------------- stage E: full weighted sums ----------------
    logic [NUM_CHAN-1:0][VW-1:0] e_sum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (e_go) begin
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (e_go) begin
            e_sum_reg <= v_sum;
        end
    end

    // Round once to nearest, then saturate.
    logic [NUM_CHAN-1:0][VW:0]     rounded;
    logic [NUM_CHAN-1:0][RW-1:0]   scaled;
    pixel_t                        result;

    always_comb begin
        for (int ch = 0; ch < NUM_CHAN; ch++) begin
            rounded[ch] = (VW + 1)'(e_sum_reg[ch]) + ROUND_C;
            scaled[ch]  = RW'(rounded[ch] >> (2 * FB));
            result[ch]  = (scaled[ch] > RW'(255)) ? CHAN_W'(255) : CHAN_W'(scaled[ch]);
        end
    end

    // ---------------- output register ----------------
    pixel_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (m_go) begin
            m_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_go && e_valid_reg) begin
            m_data_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(m_data_reg);

endmodule

`default_nettype wire
